FILE: hdl/fcst_pkg.sv
// fcst_pkg: shared constants, types and operation codes of the fixed capacity set table
// used by fcst_store and fixed_capacity_set_table; no dependencies
package fcst_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  // width of the value port and of the count field
  localparam int unsigned InW    = 32;
  localparam int unsigned CountW = 5;

  // only the low value bits that fit both the port and VALUE_WIDTH are kept
  localparam int unsigned ValW = (VALUE_WIDTH < InW) ? VALUE_WIDTH : InW;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [ValW-1:0] val_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    OpAdd      = 2'd0,
    OpRemove   = 2'd1,
    OpContains = 2'd2,
    OpClear    = 2'd3
  } op_e;

  // one write and one read port of the entry store
  typedef struct packed {
    logic we;
    idx_t waddr;
    val_t wdata;
    logic re;
    idx_t raddr;
  } mem_req_t;

endpackage

FILE: hdl/fcst_store.sv
// fcst_store: entry store of the set table, one write and one registered read per cycle
// depends on fcst_pkg
module fcst_store (
  input  logic               clk_i,
  input  fcst_pkg::mem_req_t req_i,
  output fcst_pkg::val_t     rdata_o
);
  import fcst_pkg::*;

  val_t mem_q [CAPACITY];
  val_t rdata_q;

  // contents are undefined until written, so no reset
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/fixed_capacity_set_table.sv
// fixed_capacity_set_table: packed set of up to CAPACITY distinct values with a linear scan
// depends on fcst_pkg and fcst_store
//
//   channel | direction | handshake                 | beat payload
//   in      | in        | in_valid_i / in_ready_o   | mode_i, value_i
//   out     | out       | out_valid_o / out_ready_i | ok_o, count_o, empty_res_o
//
// add, remove and contains scan the held entries through the store's single read port,
// one entry per cycle; a beat passes through accept, the occupancy reads, a compare of the
// last entry read, a step to leave the scan, then the update.
// a hit ends the scan early; a remove that hits fetches the last entry in that same cycle
// and moves it into the freed slot in place of the update step. clear goes from accept
// straight to the update. reset empties the table at once, the entries stay unwritten.
// in_ready_o is high only while the sequencer is idle; a result waiting on out_ready_i
// holds the next item in its update step, not at the input.
module fixed_capacity_set_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [fcst_pkg::InW-1:0]      value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [fcst_pkg::CountW-1:0]   count_o,
  output logic                          empty_res_o
);
  import fcst_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StMove
  } state_e;

  state_e   state_q, state_d;
  op_e      mode_q, mode_d;
  val_t     val_q, val_d;
  cnt_t     occ_q, occ_d;
  cnt_t     idx_q, idx_d;
  logic     cmp_vld_q, cmp_vld_d;
  idx_t     cmp_idx_q, cmp_idx_d;
  logic     hit_q, hit_d;
  idx_t     slot_q, slot_d;
  logic     out_valid_q, out_valid_d;
  logic     ok_q, ok_d;
  logic [CountW-1:0] count_q, count_d;
  logic     empty_q, empty_d;

  mem_req_t mem_req;
  val_t     rdata;
  logic     res_fire;
  logic     out_free;
  logic     ok_res;
  logic     match;
  cnt_t     occ_m1;

  fcst_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign match    = cmp_vld_q && (rdata == val_q);
  assign occ_m1   = occ_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    val_d       = val_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    count_d     = count_q;
    empty_d     = empty_q;
    res_fire    = 1'b0;
    ok_res      = 1'b0;

    mem_req       = '0;
    mem_req.wdata = val_q;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mode_d    = op_e'(mode_i);
          val_d     = value_i[ValW-1:0];
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          hit_d     = 1'b0;
          state_d   = (op_e'(mode_i) == OpClear) ? StUpdate : StScan;
        end
      end

      StScan: begin
        // compare the entry read last cycle while fetching the next one
        cmp_vld_d = 1'b0;
        if (match) begin
          hit_d  = 1'b1;
          slot_d = cmp_idx_q;
          if (mode_q == OpRemove) begin
            // fetch the last entry to fill the freed slot
            mem_req.re    = 1'b1;
            mem_req.raddr = occ_m1[IdxW-1:0];
            state_d       = StMove;
          end else begin
            state_d = StUpdate;
          end
        end else if (idx_q != occ_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q[IdxW-1:0];
          idx_d         = idx_q + 1'b1;
          cmp_vld_d     = 1'b1;
          cmp_idx_d     = idx_q[IdxW-1:0];
        end else if (!cmp_vld_q) begin
          state_d = StUpdate;
        end
      end

      StUpdate: begin
        if (out_free) begin
          res_fire = 1'b1;
          state_d  = StIdle;
          case (mode_q)
            OpAdd: begin
              if (!hit_q && (occ_q < cnt_t'(CAPACITY))) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = occ_q[IdxW-1:0];
                occ_d         = occ_q + 1'b1;
                ok_res        = 1'b1;
              end
            end
            OpContains: ok_res = hit_q;
            OpClear: begin
              occ_d  = '0;
              ok_res = 1'b1;
            end
            default: ok_res = 1'b0; // remove that missed
          endcase
        end
      end

      StMove: begin
        if (out_free) begin
          res_fire      = 1'b1;
          state_d       = StIdle;
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_q;
          mem_req.wdata = rdata;
          occ_d         = occ_m1;
          ok_res        = 1'b1;
        end
      end

      default: state_d = StIdle;
    endcase

    if (res_fire) begin
      out_valid_d = 1'b1;
      ok_d        = ok_res;
      count_d     = CountW'(occ_d);
      empty_d     = (occ_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      occ_q       <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= OpAdd;
      val_q       <= '0;
      cmp_idx_q   <= '0;
      slot_q      <= '0;
      ok_q        <= 1'b0;
      count_q     <= '0;
      empty_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      val_q       <= val_d;
      cmp_idx_q   <= cmp_idx_d;
      slot_q      <= slot_d;
      ok_q        <= ok_d;
      count_q     <= count_d;
      empty_q     <= empty_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign count_o     = count_q;
  assign empty_res_o = empty_q;

  // occupancy never passes capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cnt_t'(CAPACITY))
    else $error("occupancy above capacity");

  // the table is only written in the cycle that produces the result
  a_write_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> res_fire)
    else $error("store written outside a result cycle");

  // a clear leaves the table empty
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && (mode_q == OpClear)) |=> (occ_q == '0) && empty_res_o)
    else $error("clear did not empty the table");

  // the scan never reads beyond the held entries
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (idx_q <= occ_q))
    else $error("scan index beyond occupancy");

  // a match ends the scan
  a_hit_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) && match) |=> (state_q != StScan) && hit_q)
    else $error("scan continued after a match");

endmodule
